// ===== src/link_idle_pacer_admission_assert.svh =====
// Assertion macros for the link idle pacer admission block.
`ifndef LINK_IDLE_PACER_ADMISSION_ASSERT_SVH
`define LINK_IDLE_PACER_ADMISSION_ASSERT_SVH

// Property that holds in the same cycle as its trigger.
`define LIPA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Property that holds in the cycle after its trigger.
`define LIPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/lipa_pkg.sv =====
// Shared types and constants of the link idle pacer admission block.
package lipa_pkg;

  localparam int unsigned FRAME_OVERHEAD = 24;
  localparam int unsigned LEN_W          = 16;
  localparam int unsigned BYTES_W        = LEN_W + 1;
  localparam int unsigned CFG_W          = 32;
  localparam int unsigned PROD_W         = CFG_W + BYTES_W;
  localparam int unsigned WIRE_SHIFT     = 20;
  localparam int unsigned WIRE_W         = PROD_W - WIRE_SHIFT;
  localparam int unsigned NOW_W          = 63;
  localparam int unsigned IDLE_W         = 64;
  localparam int unsigned FIFO_DEPTH     = 4;
  localparam int unsigned PTR_W          = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W          = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_W-1:0] CPM_RESET       = 32'd8472494;
  localparam logic [CFG_W-1:0] MAX_QUEUE_RESET = 32'd2000;
  localparam logic [CFG_W-1:0] THROTTLE_RESET  = 32'd1000;

  typedef enum logic [1:0] {
    REG_CPM      = 2'd0,
    REG_MAXQ     = 2'd1,
    REG_THROTTLE = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_SEND    = 2'd1,
    OP_POLL    = 2'd2,
    OP_HELP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    V_SEND  = 2'd0,
    V_DEFER = 2'd1,
    V_MAY   = 2'd2,
    V_WAIT  = 2'd3
  } verdict_e;

  typedef enum logic [2:0] {
    K_PUSH     = 3'd0,
    K_PUSH_LIM = 3'd1,
    K_DEFER    = 3'd2,
    K_POLL     = 3'd3,
    K_HELP     = 3'd4,
    K_WAIT     = 3'd5
  } kind_e;

  typedef struct packed {
    logic [CFG_W-1:0] cpm;
    logic [CFG_W-1:0] max_queue;
    logic [CFG_W-1:0] throttle;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [NOW_W-1:0]  now;
    logic [IDLE_W-1:0] lim;
    logic [WIRE_W-1:0] wire_cyc;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             full;
  } fifo_st_t;

  typedef struct packed {
    logic              pop;
    logic              hold;
    logic [IDLE_W-1:0] idle;
  } back_st_t;

endpackage

// ===== src/link_idle_pacer_admission.sv =====
// Top level of the link idle pacer admission block.
// Takes one packet or poll per cycle unless in_stall_o is raised and returns one verdict
// per item, in order, on the outputs. An accepted item passes the front register, which
// holds the wire-time product and the queue limit, then a four-entry queue, and then the
// back end, which updates the 64-bit link idle time and registers the verdict. The
// sustained rate of one item per cycle while the output is not stalled is set by the
// idle-time update in the back end. Configuration writes are always taken and apply to
// items accepted afterwards.
`include "link_idle_pacer_admission_assert.svh"

module link_idle_pacer_admission (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [lipa_pkg::NOW_W-1:0]    now_i,
  input  logic [lipa_pkg::LEN_W-1:0]    pkt_len_i,
  input  logic                          is_proto_pkt_i,
  input  logic                          is_data_i,
  input  logic [31:0]                   message_length_i,
  input  logic                          any_deferred_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    verdict_o,
  output logic [lipa_pkg::NOW_W-1:0]    idle_time_after_o
);

  lipa_pkg::cfg_t     cfg_q;
  lipa_pkg::fifo_st_t fifo_st;
  lipa_pkg::back_st_t back_st;
  lipa_pkg::entry_t   front_entry;
  lipa_pkg::entry_t   fifo_entry;
  logic               front_valid;
  logic               pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cpm       <= lipa_pkg::CPM_RESET;
      cfg_q.max_queue <= lipa_pkg::MAX_QUEUE_RESET;
      cfg_q.throttle  <= lipa_pkg::THROTTLE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lipa_pkg::reg_e'(cfg_index_i))
        lipa_pkg::REG_CPM:      cfg_q.cpm       <= cfg_data_i;
        lipa_pkg::REG_MAXQ:     cfg_q.max_queue <= cfg_data_i;
        lipa_pkg::REG_THROTTLE: cfg_q.throttle  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lipa_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .fifo_st_i        (fifo_st),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .now_i            (now_i),
    .pkt_len_i        (pkt_len_i),
    .is_proto_pkt_i   (is_proto_pkt_i),
    .is_data_i        (is_data_i),
    .message_length_i (message_length_i),
    .any_deferred_i   (any_deferred_i),
    .valid_o          (front_valid),
    .entry_o          (front_entry)
  );

  lipa_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid),
    .data_i (front_entry),
    .pop_i  (pop),
    .data_o (fifo_entry),
    .st_o   (fifo_st)
  );

  lipa_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fifo_st_i         (fifo_st),
    .entry_i           (fifo_entry),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .verdict_o         (verdict_o),
    .idle_time_after_o (idle_time_after_o),
    .st_o              (back_st)
  );

  `LIPA_ASSERT_NEXT(a_accept_loads_front, in_valid_i && !in_stall_o, front_valid)
  `LIPA_ASSERT_IMPL(a_no_push_when_full, front_valid, !fifo_st.full)
  `LIPA_ASSERT_IMPL(a_pop_needs_data, back_st.pop, !fifo_st.empty)
  `LIPA_ASSERT_NEXT(a_hold_keeps_idle, back_st.pop && back_st.hold, $stable(back_st.idle))

endmodule

// ===== src/lipa_front.sv =====
// Front end: accepts items, computes wire time and limit, and classifies them.
module lipa_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lipa_pkg::cfg_t                   cfg_i,
  input  lipa_pkg::fifo_st_t               fifo_st_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic [lipa_pkg::NOW_W-1:0]       now_i,
  input  logic [lipa_pkg::LEN_W-1:0]       pkt_len_i,
  input  logic                             is_proto_pkt_i,
  input  logic                             is_data_i,
  input  logic [31:0]                      message_length_i,
  input  logic                             any_deferred_i,
  output logic                             valid_o,
  output lipa_pkg::entry_t                 entry_o
);

  logic                              valid_q;
  lipa_pkg::entry_t                  entry_q;
  lipa_pkg::entry_t                  entry_d;
  logic                              accept;
  logic [lipa_pkg::BYTES_W-1:0]      bytes;
  logic [lipa_pkg::PROD_W-1:0]       prod;
  logic [lipa_pkg::CFG_W-1:0]        lim_add;

  assign in_stall_o = (fifo_st_i.count == lipa_pkg::CNT_W'(lipa_pkg::FIFO_DEPTH)) ||
                      (valid_q &&
                       fifo_st_i.count == lipa_pkg::CNT_W'(lipa_pkg::FIFO_DEPTH - 1));
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    bytes   = {1'b0, pkt_len_i} + lipa_pkg::BYTES_W'(lipa_pkg::FRAME_OVERHEAD);
    prod    = lipa_pkg::PROD_W'(cfg_i.cpm) * lipa_pkg::PROD_W'(bytes);
    lim_add = (lipa_pkg::op_e'(op_i) == lipa_pkg::OP_HELP) ? (cfg_i.max_queue >> 1)
                                                           : cfg_i.max_queue;
    entry_d.now      = now_i;
    entry_d.wire_cyc = prod[lipa_pkg::PROD_W-1:lipa_pkg::WIRE_SHIFT];
    entry_d.lim      = {1'b0, now_i} + lipa_pkg::IDLE_W'(lim_add);
    unique case (lipa_pkg::op_e'(op_i))
      lipa_pkg::OP_ENQUEUE: begin
        if (!is_proto_pkt_i || !is_data_i || message_length_i < cfg_i.throttle) begin
          entry_d.kind = lipa_pkg::K_PUSH;
        end else if (any_deferred_i) begin
          entry_d.kind = lipa_pkg::K_DEFER;
        end else begin
          entry_d.kind = lipa_pkg::K_PUSH_LIM;
        end
      end
      lipa_pkg::OP_SEND: entry_d.kind = lipa_pkg::K_PUSH;
      lipa_pkg::OP_POLL: entry_d.kind = lipa_pkg::K_POLL;
      lipa_pkg::OP_HELP: entry_d.kind = any_deferred_i ? lipa_pkg::K_HELP : lipa_pkg::K_WAIT;
      default:           entry_d.kind = lipa_pkg::K_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

// ===== src/lipa_fifo.sv =====
// Short queue of classified items between the front and back ends.
module lipa_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lipa_pkg::entry_t   data_i,
  input  logic               pop_i,
  output lipa_pkg::entry_t   data_o,
  output lipa_pkg::fifo_st_t st_o
);

  lipa_pkg::entry_t               mem_q [lipa_pkg::FIFO_DEPTH];
  logic [lipa_pkg::PTR_W-1:0]     wptr_q;
  logic [lipa_pkg::PTR_W-1:0]     rptr_q;
  logic [lipa_pkg::CNT_W-1:0]     cnt_q;
  logic [lipa_pkg::CNT_W-1:0]     cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + lipa_pkg::CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - lipa_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= wptr_q + lipa_pkg::PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + lipa_pkg::PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o      = mem_q[rptr_q];
  assign st_o.count  = cnt_q;
  assign st_o.empty  = (cnt_q == '0);
  assign st_o.full   = (cnt_q == lipa_pkg::CNT_W'(lipa_pkg::FIFO_DEPTH));

endmodule

// ===== src/lipa_back.sv =====
// Back end: applies items to the link idle time and registers the verdict.
module lipa_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lipa_pkg::fifo_st_t            fifo_st_i,
  input  lipa_pkg::entry_t              entry_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    verdict_o,
  output logic [lipa_pkg::NOW_W-1:0]    idle_time_after_o,
  output lipa_pkg::back_st_t            st_o
);

  logic [lipa_pkg::IDLE_W-1:0] idle_q;
  logic [lipa_pkg::IDLE_W-1:0] idle_d;
  logic [lipa_pkg::IDLE_W-1:0] now64;
  logic [lipa_pkg::IDLE_W-1:0] nxt;
  logic                        out_valid_q;
  lipa_pkg::verdict_e          verdict_q;
  lipa_pkg::verdict_e          verdict_d;
  logic [lipa_pkg::NOW_W-1:0]  idle_out_q;
  logic                        lt;
  logic                        over;
  logic                        hold;

  assign pop_o = !fifo_st_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    now64 = {1'b0, entry_i.now};
    lt    = idle_q < now64;
    over  = idle_q > entry_i.lim;
    nxt   = (lt ? now64 : idle_q) + lipa_pkg::IDLE_W'(entry_i.wire_cyc);
    idle_d    = idle_q;
    verdict_d = lipa_pkg::V_SEND;
    hold      = 1'b1;
    unique case (entry_i.kind)
      lipa_pkg::K_PUSH: begin
        idle_d = nxt;
        hold   = 1'b0;
      end
      lipa_pkg::K_PUSH_LIM: begin
        if (!lt && over) begin
          verdict_d = lipa_pkg::V_DEFER;
        end else begin
          idle_d = nxt;
          hold   = 1'b0;
        end
      end
      lipa_pkg::K_DEFER: verdict_d = lipa_pkg::V_DEFER;
      lipa_pkg::K_POLL:  verdict_d = over ? lipa_pkg::V_WAIT : lipa_pkg::V_MAY;
      lipa_pkg::K_HELP:  verdict_d = over ? lipa_pkg::V_WAIT : lipa_pkg::V_MAY;
      lipa_pkg::K_WAIT:  verdict_d = lipa_pkg::V_WAIT;
      default:           verdict_d = lipa_pkg::V_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        idle_q      <= idle_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      verdict_q  <= verdict_d;
      idle_out_q <= idle_d[lipa_pkg::NOW_W-1:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign verdict_o         = verdict_q;
  assign idle_time_after_o = idle_out_q;
  assign st_o.pop          = pop_o;
  assign st_o.hold         = hold;
  assign st_o.idle         = idle_q;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the link idle pacer admission block.
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam logic [lipa_pkg::NOW_W-1:0] NOW_TOP = '1;

  typedef struct {
    lipa_pkg::op_e              op;
    logic [lipa_pkg::NOW_W-1:0] now;
    logic [lipa_pkg::LEN_W-1:0] len;
    logic                       proto;
    logic                       data;
    logic [31:0]                mlen;
    logic                       deferred;
  } pkt_t;

  typedef struct {
    lipa_pkg::verdict_e         verdict;
    logic [lipa_pkg::NOW_W-1:0] idle;
  } decision_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [1:0]                  cfg_index_i = '0;
  logic [31:0]                 cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [1:0]                  op_i = '0;
  logic [lipa_pkg::NOW_W-1:0]  now_i = '0;
  logic [lipa_pkg::LEN_W-1:0]  pkt_len_i = '0;
  logic                        is_proto_pkt_i = 1'b0;
  logic                        is_data_i = 1'b0;
  logic [31:0]                 message_length_i = '0;
  logic                        any_deferred_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [1:0]                  verdict_o;
  logic [lipa_pkg::NOW_W-1:0]  idle_time_after_o;

  logic [lipa_pkg::CFG_W-1:0]  cpm_m = lipa_pkg::CPM_RESET;
  logic [lipa_pkg::CFG_W-1:0]  maxq_m = lipa_pkg::MAX_QUEUE_RESET;
  logic [lipa_pkg::CFG_W-1:0]  throttle_m = lipa_pkg::THROTTLE_RESET;
  logic [lipa_pkg::IDLE_W-1:0] idle_time_m = '0;
  logic [lipa_pkg::NOW_W-1:0]  wall_now = '0;

  decision_t   pending_decisions[$];
  int unsigned send_gap_pct = 24;
  int unsigned recv_stall_pct = 55;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  link_idle_pacer_admission dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .now_i            (now_i),
    .pkt_len_i        (pkt_len_i),
    .is_proto_pkt_i   (is_proto_pkt_i),
    .is_data_i        (is_data_i),
    .message_length_i (message_length_i),
    .any_deferred_i   (any_deferred_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .verdict_o        (verdict_o),
    .idle_time_after_o(idle_time_after_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [lipa_pkg::IDLE_W-1:0] wire_time(logic [lipa_pkg::LEN_W-1:0] len);
    logic [lipa_pkg::IDLE_W-1:0] bytes;
    bytes = lipa_pkg::IDLE_W'(len) + lipa_pkg::IDLE_W'(lipa_pkg::FRAME_OVERHEAD);
    return (lipa_pkg::IDLE_W'(cpm_m) * bytes) >> lipa_pkg::WIRE_SHIFT;
  endfunction

  function automatic logic advance_idle(logic [lipa_pkg::NOW_W-1:0] now,
                                        logic [lipa_pkg::LEN_W-1:0] len,
                                        logic limited);
    logic [lipa_pkg::IDLE_W-1:0] now64;
    now64 = lipa_pkg::IDLE_W'(now);
    if (idle_time_m < now64) begin
      idle_time_m = now64 + wire_time(len);
      return 1'b1;
    end
    if (limited && (idle_time_m - now64) > lipa_pkg::IDLE_W'(maxq_m)) return 1'b0;
    idle_time_m = idle_time_m + wire_time(len);
    return 1'b1;
  endfunction

  function automatic decision_t decide_admission(pkt_t p);
    decision_t d;
    logic [lipa_pkg::IDLE_W-1:0] now64;
    now64 = lipa_pkg::IDLE_W'(p.now);
    case (p.op)
      lipa_pkg::OP_ENQUEUE: begin
        if (!p.proto || !p.data || p.mlen < throttle_m) begin
          void'(advance_idle(p.now, p.len, 1'b0));
          d.verdict = lipa_pkg::V_SEND;
        end else if (!p.deferred && advance_idle(p.now, p.len, 1'b1)) begin
          d.verdict = lipa_pkg::V_SEND;
        end else begin
          d.verdict = lipa_pkg::V_DEFER;
        end
      end
      lipa_pkg::OP_SEND: begin
        void'(advance_idle(p.now, p.len, 1'b0));
        d.verdict = lipa_pkg::V_SEND;
      end
      lipa_pkg::OP_POLL: begin
        if (now64 + lipa_pkg::IDLE_W'(maxq_m) < idle_time_m) d.verdict = lipa_pkg::V_WAIT;
        else d.verdict = lipa_pkg::V_MAY;
      end
      default: begin
        if (p.deferred && !(now64 + lipa_pkg::IDLE_W'(maxq_m >> 1) < idle_time_m))
          d.verdict = lipa_pkg::V_MAY;
        else d.verdict = lipa_pkg::V_WAIT;
      end
    endcase
    d.idle = idle_time_m[lipa_pkg::NOW_W-1:0];
    return d;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] expected, logic [63:0] actual);
    $display("mismatch at cycle %0d: %s expected %0h got %0h",
             cycle_count, what, expected, actual);
    errors++;
  endtask

  always @(posedge clk_i) begin : check_results
    decision_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_decisions.size() == 0) begin
        report_mismatch("unexpected result, verdict", '0, 64'(verdict_o));
      end else begin
        want = pending_decisions.pop_front();
        if (verdict_o !== want.verdict)
          report_mismatch("verdict", 64'(want.verdict), 64'(verdict_o));
        if (idle_time_after_o !== want.idle)
          report_mismatch("idle_time_after", 64'(want.idle), 64'(idle_time_after_o));
      end
    end
  end

  function automatic pkt_t mk_pkt(lipa_pkg::op_e op, logic [lipa_pkg::NOW_W-1:0] now,
                                  logic [lipa_pkg::LEN_W-1:0] len,
                                  logic proto, logic data, logic [31:0] mlen,
                                  logic deferred);
    pkt_t p;
    p.op = op;
    p.now = now;
    p.len = len;
    p.proto = proto;
    p.data = data;
    p.mlen = mlen;
    p.deferred = deferred;
    return p;
  endfunction

  function automatic logic [lipa_pkg::NOW_W-1:0] idle_now();
    return idle_time_m[lipa_pkg::NOW_W-1:0];
  endfunction

  task automatic send_item(pkt_t p);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    op_i = p.op;
    now_i = p.now;
    pkt_len_i = p.len;
    is_proto_pkt_i = p.proto;
    is_data_i = p.data;
    message_length_i = p.mlen;
    any_deferred_i = p.deferred;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_decisions.push_back(decide_admission(p));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      lipa_pkg::REG_CPM:      cpm_m = val;
      lipa_pkg::REG_MAXQ:     maxq_m = val;
      lipa_pkg::REG_THROTTLE: throttle_m = val;
      default:                ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [lipa_pkg::NOW_W-1:0] stale_now();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return wall_now - lipa_pkg::NOW_W'(r % (64'(wall_now) + 64'd1));
  endfunction

  function automatic pkt_t gen_random_pkt();
    pkt_t p;
    logic [63:0] step_max;
    logic [63:0] r64;
    int unsigned pick;
    step_max = ((64'(cpm_m) * 64'd1524) >> lipa_pkg::WIRE_SHIFT) + 64'(maxq_m >> 1) + 64'd16;
    if (step_max > 64'h100_0000_0000) step_max = 64'h100_0000_0000;
    r64 = {$urandom, $urandom};
    wall_now = wall_now + lipa_pkg::NOW_W'(r64 % (step_max + 64'd1));
    if ($urandom_range(99) < 2 && wall_now[lipa_pkg::NOW_W-1:lipa_pkg::NOW_W-3] == '0) begin
      r64 = {$urandom, $urandom};
      wall_now = wall_now + lipa_pkg::NOW_W'(r64 >> $urandom_range(6, 63));
    end
    pick = $urandom_range(99);
    if (pick < 8) begin
      p.op = lipa_pkg::op_e'($urandom_range(3));
      p.now = $urandom_range(1) ? stale_now() : wall_now;
      p.len = lipa_pkg::LEN_W'($urandom);
      p.proto = 1'($urandom_range(1));
      p.data = 1'($urandom_range(1));
      p.mlen = $urandom;
      p.deferred = 1'($urandom_range(1));
    end else begin
      pick = $urandom_range(99);
      if (pick < 55) p.op = lipa_pkg::OP_ENQUEUE;
      else if (pick < 70) p.op = lipa_pkg::OP_SEND;
      else if (pick < 85) p.op = lipa_pkg::OP_POLL;
      else p.op = lipa_pkg::OP_HELP;
      p.now = ($urandom_range(9) == 0) ? stale_now() : wall_now;
      p.len = ($urandom_range(6) == 0) ? lipa_pkg::LEN_W'($urandom)
                                       : lipa_pkg::LEN_W'($urandom_range(40, 1538));
      p.proto = ($urandom_range(99) < 85);
      p.data = ($urandom_range(99) < 85);
      p.mlen = $urandom_range(1) ? $urandom_range(0, 10000) : $urandom;
      p.deferred = ($urandom_range(3) == 0);
    end
    return p;
  endfunction

  task automatic test_reset_defaults();
    send_item(mk_pkt(lipa_pkg::OP_ENQUEUE, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    send_item(mk_pkt(lipa_pkg::OP_SEND, '0, '1, 1'b1, 1'b1, '1, 1'b1));
    send_item(mk_pkt(lipa_pkg::OP_POLL, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    send_item(mk_pkt(lipa_pkg::OP_HELP, '0, '0, 1'b0, 1'b0, '0, 1'b1));
    send_item(mk_pkt(lipa_pkg::OP_HELP, idle_now(), '0, 1'b0, 1'b0, '0, 1'b0));
  endtask

  task automatic test_queue_limits();
    send_item(mk_pkt(lipa_pkg::OP_HELP, idle_now() - lipa_pkg::NOW_W'(maxq_m >> 1), '0,
                     1'b0, 1'b0, '0, 1'b1));
    send_item(mk_pkt(lipa_pkg::OP_HELP, idle_now() - lipa_pkg::NOW_W'(maxq_m >> 1) - 1'b1,
                     '0, 1'b0, 1'b0, '0, 1'b1));
    send_item(mk_pkt(lipa_pkg::OP_POLL, idle_now() - lipa_pkg::NOW_W'(maxq_m), '0,
                     1'b0, 1'b0, '0, 1'b0));
    send_item(mk_pkt(lipa_pkg::OP_POLL, idle_now() - lipa_pkg::NOW_W'(maxq_m) - 1'b1, '0,
                     1'b0, 1'b0, '0, 1'b0));
    send_item(mk_pkt(lipa_pkg::OP_ENQUEUE, idle_now() - lipa_pkg::NOW_W'(maxq_m), 16'd1500,
                     1'b1, 1'b1, throttle_m, 1'b0));
    send_item(mk_pkt(lipa_pkg::OP_ENQUEUE, idle_now() - lipa_pkg::NOW_W'(maxq_m) - 1'b1,
                     16'd1500, 1'b1, 1'b1, throttle_m, 1'b0));
    send_item(mk_pkt(lipa_pkg::OP_ENQUEUE, idle_now() + 5, 16'd1500, 1'b1, 1'b1, throttle_m,
                     1'b1));
    send_item(mk_pkt(lipa_pkg::OP_ENQUEUE, '0, 16'd1500, 1'b1, 1'b0, throttle_m, 1'b1));
    send_item(mk_pkt(lipa_pkg::OP_ENQUEUE, idle_now(), 16'd1500, 1'b1, 1'b1, throttle_m - 1,
                     1'b1));
    send_item(mk_pkt(lipa_pkg::OP_ENQUEUE, idle_now() + 100, 16'd1500, 1'b1, 1'b1,
                     throttle_m, 1'b0));
  endtask

  task automatic test_config_extremes();
    write_reg(lipa_pkg::REG_CPM, '0);
    write_reg(lipa_pkg::REG_MAXQ, '0);
    write_reg(lipa_pkg::REG_THROTTLE, '0);
    write_reg(REG_UNUSED, '1);
    send_item(mk_pkt(lipa_pkg::OP_ENQUEUE, idle_now(), 16'd1500, 1'b1, 1'b1, '0, 1'b0));
    send_item(mk_pkt(lipa_pkg::OP_POLL, idle_now(), '0, 1'b0, 1'b0, '0, 1'b0));
    send_item(mk_pkt(lipa_pkg::OP_ENQUEUE, idle_now() - 1'b1, 16'd1500, 1'b1, 1'b1, '0,
                     1'b0));
    write_reg(lipa_pkg::REG_CPM, '1);
    write_reg(lipa_pkg::REG_MAXQ, '1);
    write_reg(lipa_pkg::REG_THROTTLE, '1);
    send_item(mk_pkt(lipa_pkg::OP_ENQUEUE, idle_now() + 1'b1, '1, 1'b1, 1'b1, '1, 1'b0));
    send_item(mk_pkt(lipa_pkg::OP_ENQUEUE, idle_now(), '1, 1'b1, 1'b1, 32'hFFFF_FFFE,
                     1'b0));
    send_item(mk_pkt(lipa_pkg::OP_POLL, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    send_item(mk_pkt(lipa_pkg::OP_HELP, '0, '0, 1'b0, 1'b0, '0, 1'b1));
    write_reg(lipa_pkg::REG_CPM, lipa_pkg::CPM_RESET);
    write_reg(lipa_pkg::REG_MAXQ, lipa_pkg::MAX_QUEUE_RESET);
    write_reg(lipa_pkg::REG_THROTTLE, lipa_pkg::THROTTLE_RESET);
  endtask

  task automatic test_random_traffic(int unsigned gap_pct, int unsigned stall_pct,
                                     int unsigned count);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    write_reg(lipa_pkg::REG_CPM, ($urandom_range(99) < 15) ? $urandom
                                                           : $urandom_range(2000000, 40000000));
    write_reg(lipa_pkg::REG_MAXQ, ($urandom_range(99) < 15) ? $urandom
                                                            : $urandom_range(0, 20000));
    write_reg(lipa_pkg::REG_THROTTLE, ($urandom_range(99) < 15) ? $urandom
                                                                : $urandom_range(0, 5000));
    if (wall_now < idle_now()) wall_now = idle_now();
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      send_item(gen_random_pkt());
    end
  endtask

  task automatic test_clock_top();
    write_reg(lipa_pkg::REG_CPM, '1);
    write_reg(lipa_pkg::REG_MAXQ, lipa_pkg::MAX_QUEUE_RESET);
    write_reg(lipa_pkg::REG_THROTTLE, lipa_pkg::THROTTLE_RESET);
    send_item(mk_pkt(lipa_pkg::OP_SEND, NOW_TOP, '1, 1'b1, 1'b1, '1, 1'b0));
    send_item(mk_pkt(lipa_pkg::OP_POLL, NOW_TOP, '0, 1'b0, 1'b0, '0, 1'b0));
    send_item(mk_pkt(lipa_pkg::OP_ENQUEUE, NOW_TOP, 16'd1500, 1'b1, 1'b1, '1, 1'b0));
    send_item(mk_pkt(lipa_pkg::OP_HELP, NOW_TOP, '0, 1'b0, 1'b0, '0, 1'b1));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_queue_limits();
    test_config_extremes();
    test_random_traffic(24, 55, 416);
    test_random_traffic(55, 24, 416);
    test_random_traffic(0, 0, 418);
    test_clock_top();
    drain_results();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
